// ----- rtl/montgomery_mul_384_unit_macros.svh -----
// ---------------------------------------------------------------------------
// montgomery multiplier assertion macros
// shared property shapes, clocked on clk and quiet while rst is high
// ---------------------------------------------------------------------------
`ifndef MONTGOMERY_MUL_384_UNIT_MACROS_SVH
`define MONTGOMERY_MUL_384_UNIT_MACROS_SVH

// same-cycle implication
`define MM384_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MM384_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mm384_pkg.sv -----
// ---------------------------------------------------------------------------
// mm384_pkg
// widths, register codes and reset constants of the montgomery multiplier
// ---------------------------------------------------------------------------
package mm384_pkg;

  localparam int LIMB_W    = 64;
  localparam int MAX_LIMBS = 6;
  localparam int RES_W     = LIMB_W * MAX_LIMBS;
  localparam int IN_W      = 2 * RES_W;
  localparam int CFG_IDX_W = 3;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [MAX_LIMBS-1:0][LIMB_W-1:0] mod_t;

  // register indexes: modulus limbs are 0..5, then the inverse word
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_INV = 3'd6;

  // reset: p-384 prime and its montgomery constant
  localparam mod_t MOD_RESET = {
    64'hffffffffffffffff, 64'hffffffffffffffff, 64'hffffffffffffffff,
    64'hfffffffffffffffe, 64'hffffffff00000000, 64'h00000000ffffffff
  };
  localparam limb_t NEG_INV_RESET = 64'h0000000100000001;

endpackage

// ----- rtl/mm384_row.sv -----
// ---------------------------------------------------------------------------
// mm384_row
// one cios row in eight stages: t += a_i*b, u = t0*ninv, t = (t + u*m) >> 64
// ---------------------------------------------------------------------------
`include "montgomery_mul_384_unit_macros.svh"

module mm384_row #(
  parameter int LIMB_COUNT = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  mm384_pkg::mod_t            modulus,
  input  mm384_pkg::limb_t           ninv,
  input  logic                       in_valid,
  input  logic [64*LIMB_COUNT+65:0]  in_t,
  input  logic [64*LIMB_COUNT-1:0]   in_a,
  input  logic [64*LIMB_COUNT-1:0]   in_b,
  output logic                       out_valid,
  output logic [64*LIMB_COUNT+65:0]  out_t,
  output logic [64*LIMB_COUNT-1:0]   out_a,
  output logic [64*LIMB_COUNT-1:0]   out_b
);

  localparam int N  = 64 * LIMB_COUNT;
  localparam int TW = N + 66;

  logic [7:0] v;

  // stage 1: partial products of a_i * b_j
  logic [LIMB_COUNT-1:0][3:0][63:0] pp1, pp1_next;
  logic [TW-1:0] t1;
  logic [N-1:0]  a1, b1;
  // stage 2: full products
  logic [LIMB_COUNT-1:0][127:0] pr2, pr2_next;
  logic [TW-1:0] t2;
  logic [N-1:0]  a2, b2;
  // stage 3: accumulated
  logic [N+63:0] pe3, po3;
  logic [TW-1:0] t3, t3_next;
  logic [N-1:0]  a3, b3;
  // stage 4: quotient word partials
  logic [63:0]   u00;
  logic [31:0]   umid;
  logic [TW-1:0] t4;
  logic [N-1:0]  a4, b4;
  // stage 5: quotient word
  logic [63:0]   u5;
  logic [TW-1:0] t5;
  logic [N-1:0]  a5, b5;
  // stage 6: partial products of u * m_j
  logic [LIMB_COUNT-1:0][3:0][63:0] qp6, qp6_next;
  logic [TW-1:0] t6;
  logic [N-1:0]  a6, b6;
  // stage 7: full products
  logic [LIMB_COUNT-1:0][127:0] qr7, qr7_next;
  logic [TW-1:0] t7;
  logic [N-1:0]  a7, b7;
  // stage 8: reduced and shifted
  logic [N+63:0] qe7, qo7;
  logic [TW-1:0] t8, t8_next;
  logic [TW+1:0] red_sum;
  logic [N-1:0]  a8, b8;

  logic [63:0] x3;
  logic [63:0] p01, p10;

  always_comb begin
    for (int j = 0; j < LIMB_COUNT; j++) begin
      pp1_next[j][0] = in_a[31:0]  * in_b[64*j +: 32];
      pp1_next[j][1] = in_a[31:0]  * in_b[64*j+32 +: 32];
      pp1_next[j][2] = in_a[63:32] * in_b[64*j +: 32];
      pp1_next[j][3] = in_a[63:32] * in_b[64*j+32 +: 32];
      pr2_next[j] = {64'd0, pp1[j][0]} + {32'd0, pp1[j][1], 32'd0}
                  + {32'd0, pp1[j][2], 32'd0} + {pp1[j][3], 64'd0};
      qp6_next[j][0] = u5[31:0]  * modulus[j][31:0];
      qp6_next[j][1] = u5[31:0]  * modulus[j][63:32];
      qp6_next[j][2] = u5[63:32] * modulus[j][31:0];
      qp6_next[j][3] = u5[63:32] * modulus[j][63:32];
      qr7_next[j] = {64'd0, qp6[j][0]} + {32'd0, qp6[j][1], 32'd0}
                  + {32'd0, qp6[j][2], 32'd0} + {qp6[j][3], 64'd0};
    end
    // even and odd products do not overlap among themselves
    pe3 = '0;
    po3 = '0;
    qe7 = '0;
    qo7 = '0;
    for (int j = 0; j < LIMB_COUNT; j++) begin
      if (j % 2 == 0) begin
        pe3[64*j +: 128] = pr2[j];
        qe7[64*j +: 128] = qr7[j];
      end else begin
        po3[64*j +: 128] = pr2[j];
        qo7[64*j +: 128] = qr7[j];
      end
    end
    t3_next = t2 + TW'(pe3) + TW'(po3);
    red_sum = {2'b00, t7} + (TW + 2)'(qe7) + (TW + 2)'(qo7);
    t8_next = TW'(red_sum >> 64);
    x3  = t3[63:0];
    p01 = x3[31:0]  * ninv[63:32];
    p10 = x3[63:32] * ninv[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp1 <= pp1_next;  t1 <= in_t;     a1 <= in_a;  b1 <= in_b;
      pr2 <= pr2_next;  t2 <= t1;       a2 <= a1;    b2 <= b1;
      t3  <= t3_next;   a3 <= a2;       b3 <= b2;
      u00 <= x3[31:0] * ninv[31:0];
      umid <= p01[31:0] + p10[31:0];
      t4  <= t3;        a4 <= a3;       b4 <= b3;
      u5  <= u00 + {umid, 32'd0};
      t5  <= t4;        a5 <= a4;       b5 <= b4;
      qp6 <= qp6_next;  t6 <= t5;       a6 <= a5;    b6 <= b5;
      qr7 <= qr7_next;  t7 <= t6;       a7 <= a6;    b7 <= b6;
      t8  <= t8_next;   a8 <= a7 >> 64; b8 <= b7;
    end
  end

  assign out_valid = v[7];
  assign out_t     = t8;
  assign out_a     = a8;
  assign out_b     = b8;

  // the reduced accumulator stays below 2^(N+2) for any operands
  `MM384_ASSERT_IMPL(a_acc_bound, v[7], (t8 >> (N + 2)) == '0, "row accumulator overflow")
  `MM384_ASSERT_NEXT(a_stall_hold, !en, $stable(v), "row valids moved during stall")

endmodule

// ----- rtl/mm384_final.sv -----
// ---------------------------------------------------------------------------
// mm384_final
// conditional subtraction of the modulus and the output register
// ---------------------------------------------------------------------------
`include "montgomery_mul_384_unit_macros.svh"

module mm384_final #(
  parameter int LIMB_COUNT = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  mm384_pkg::mod_t            modulus,
  input  logic                       in_valid,
  input  logic [64*LIMB_COUNT+65:0]  in_t,
  output logic                       out_valid,
  output logic [mm384_pkg::RES_W-1:0] out_data
);

  localparam int N  = 64 * LIMB_COUNT;
  localparam int RW = mm384_pkg::RES_W;

  logic [RW-1:0] mflat;
  logic [N:0]    diff;
  logic          v1, carry_hi, ge;
  logic [N-1:0]  tl, dl;
  logic [N-1:0]  res;

  assign mflat = modulus;
  assign diff  = {1'b0, in_t[N-1:0]} - {1'b0, mflat[N-1:0]};
  assign res   = (carry_hi || ge) ? dl : tl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tl       <= in_t[N-1:0];
      dl       <= diff[N-1:0];
      ge       <= !diff[N];
      carry_hi <= |in_t[N+65:N];
      out_data <= RW'(res);
    end
  end

  // limbs above the active count read as zero
  `MM384_ASSERT_IMPL(a_upper_zero, out_valid, (out_data >> N) == '0, "upper limbs not zero")

endmodule

// ----- rtl/montgomery_mul_384_unit.sv -----
// each input word passes through LIMB_COUNT cios rows, then the conditional subtraction and output registers
// throughput: one word per cycle while the output is not stalled; each cios row is an eight-stage pipeline
// a stall on the output holds every stage in place
// reset clears all valids and loads the p-384 modulus and its inverse word
// ---------------------------------------------------------------------------
// montgomery_mul_384_unit
// pipelined 384-bit cios montgomery multiplier with programmable modulus
// ---------------------------------------------------------------------------
module montgomery_mul_384_unit #(
  parameter int LIMB_COUNT = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // a_limb0..a_limb5, b_limb0..b_limb5
  input  logic [mm384_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_limb0..result_limb5
  output logic [mm384_pkg::RES_W-1:0]         m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mm384_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                         cfg_data
);

  localparam int N  = 64 * LIMB_COUNT;
  localparam int TW = N + 66;

  mm384_pkg::mod_t  modulus;
  mm384_pkg::limb_t ninv;
  logic             en;

  logic [LIMB_COUNT:0]         rv;
  logic [LIMB_COUNT:0][TW-1:0] rt;
  logic [LIMB_COUNT:0][N-1:0]  ra, rb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mm384_pkg::MOD_RESET;
      ninv    <= mm384_pkg::NEG_INV_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == mm384_pkg::CFG_NEG_INV) begin
        ninv <= cfg_data;
      end else if (cfg_index < mm384_pkg::CFG_NEG_INV) begin
        modulus[cfg_index] <= cfg_data;
      end
    end
  end

  // whole pipeline advances unless the output word is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign rv[0] = s_axis_tvalid;
  assign rt[0] = '0;
  assign ra[0] = s_axis_tdata[N-1:0];
  assign rb[0] = s_axis_tdata[mm384_pkg::RES_W +: N];

  for (genvar i = 0; i < LIMB_COUNT; i++) begin : g_row
    mm384_row #(.LIMB_COUNT(LIMB_COUNT)) u_row (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .modulus   (modulus),
      .ninv      (ninv),
      .in_valid  (rv[i]),
      .in_t      (rt[i]),
      .in_a      (ra[i]),
      .in_b      (rb[i]),
      .out_valid (rv[i+1]),
      .out_t     (rt[i+1]),
      .out_a     (ra[i+1]),
      .out_b     (rb[i+1])
    );
  end

  mm384_final #(.LIMB_COUNT(LIMB_COUNT)) u_final (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .modulus   (modulus),
    .in_valid  (rv[LIMB_COUNT]),
    .in_t      (rt[LIMB_COUNT]),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- sim/montgomery_mul_384_unit_checker.sv -----
// ---------------------------------------------------------------------------
// montgomery_mul_384_unit_checker
// watches the operand, result and register channels, predicts each product
// with its own cios model and compares it limb by limb in arrival order
// ---------------------------------------------------------------------------
module montgomery_mul_384_unit_checker #(
  parameter int LIMB_COUNT = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [mm384_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [mm384_pkg::RES_W-1:0]     m_axis_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mm384_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  output int                              errors,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LW = mm384_pkg::LIMB_W;
  localparam int ML = mm384_pkg::MAX_LIMBS;
  localparam int RW = mm384_pkg::RES_W;

  mm384_pkg::mod_t  modulus;
  mm384_pkg::limb_t neg_inv;
  logic [RW-1:0] expected_products[$];

  function automatic logic [RW-1:0] mont_product(input logic [mm384_pkg::IN_W-1:0] w);
    mm384_pkg::limb_t t[0:ML+1];
    mm384_pkg::limb_t a[0:ML-1];
    mm384_pkg::limb_t b[0:ML-1];
    logic [127:0] acc;
    logic [64:0] sum;
    mm384_pkg::limb_t c, u, br;
    logic sub, ge, decided;
    logic [RW-1:0] r;
    for (int j = 0; j < ML + 2; j++) t[j] = '0;
    for (int j = 0; j < ML; j++) begin
      a[j] = w[j*LW +: LW];
      b[j] = w[(ML+j)*LW +: LW];
    end
    for (int i = 0; i < LIMB_COUNT; i++) begin
      c = '0;
      for (int j = 0; j < LIMB_COUNT; j++) begin
        acc = {64'd0, t[j]} + {64'd0, a[i]} * {64'd0, b[j]} + {64'd0, c};
        t[j] = acc[63:0];
        c = acc[127:64];
      end
      sum = {1'b0, t[LIMB_COUNT]} + {1'b0, c};
      t[LIMB_COUNT+1] = {63'd0, sum[64]};
      t[LIMB_COUNT] = sum[63:0];
      // reduction: u chosen so the low word cancels
      u = t[0] * neg_inv;
      acc = {64'd0, t[0]} + {64'd0, u} * {64'd0, modulus[0]};
      c = acc[127:64];
      for (int j = 1; j < LIMB_COUNT; j++) begin
        acc = {64'd0, t[j]} + {64'd0, u} * {64'd0, modulus[j]} + {64'd0, c};
        t[j-1] = acc[63:0];
        c = acc[127:64];
      end
      sum = {1'b0, t[LIMB_COUNT]} + {1'b0, c};
      t[LIMB_COUNT-1] = sum[63:0];
      t[LIMB_COUNT] = t[LIMB_COUNT+1] + {63'd0, sum[64]};
      t[LIMB_COUNT+1] = '0;
    end
    ge = 1'b1;
    decided = 1'b0;
    for (int j = LIMB_COUNT - 1; j >= 0; j--) begin
      if (!decided && t[j] != modulus[j]) begin
        ge = t[j] > modulus[j];
        decided = 1'b1;
      end
    end
    sub = (t[LIMB_COUNT] != 0) || ge;
    br = '0;
    r = '0;
    for (int j = 0; j < LIMB_COUNT; j++) begin
      if (sub) begin
        sum = {1'b0, t[j]} - {1'b0, modulus[j]} - {1'b0, br};
        r[j*LW +: LW] = sum[63:0];
        br = {63'd0, sum[64]};
      end else begin
        r[j*LW +: LW] = t[j];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [RW-1:0] want;
    if (rst) begin
      modulus = mm384_pkg::MOD_RESET;
      neg_inv = mm384_pkg::NEG_INV_RESET;
      expected_products.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mm384_pkg::CFG_NEG_INV) neg_inv = cfg_data;
        else if (cfg_index < ML) modulus[cfg_index] = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_products.push_back(mont_product(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_products.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_products.pop_front();
          for (int j = 0; j < ML; j++)
            if (m_axis_tdata[j*LW +: LW] !== want[j*LW +: LW]) begin
              $display("%0t: result limb %0d expected %h actual %h", $time, j,
                       want[j*LW +: LW], m_axis_tdata[j*LW +: LW]);
              errors++;
            end
        end
      end
    end
    outstanding = expected_products.size();
  end

endmodule

// ----- sim/montgomery_mul_384_unit_tb.sv -----
// ---------------------------------------------------------------------------
// montgomery_mul_384_unit_tb
// drives directed and random operand words through several modulus settings
// with random stalls on both streams; the checker judges every product
// ---------------------------------------------------------------------------
module montgomery_mul_384_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ML  = mm384_pkg::MAX_LIMBS;
  localparam int CIW = mm384_pkg::CFG_IDX_W;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [mm384_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [mm384_pkg::RES_W-1:0] m_axis_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CIW-1:0]              cfg_index = '0;
  logic [63:0]                 cfg_data = '0;
  int errors;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  mm384_pkg::mod_t cur_mod = mm384_pkg::MOD_RESET;

  montgomery_mul_384_unit DUT (.*);

  montgomery_mul_384_unit_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic mm384_pkg::limb_t rand_limb();
    return {$urandom, $urandom};
  endfunction

  // newton iteration for m0^-1 mod 2^64, then negated
  function automatic mm384_pkg::limb_t neg_inverse(input mm384_pkg::limb_t m0);
    mm384_pkg::limb_t x;
    x = m0;
    repeat (6) x = x * (64'd2 - m0 * x);
    return -x;
  endfunction

  task automatic send_word(input mm384_pkg::mod_t a, input mm384_pkg::mod_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input mm384_pkg::limb_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_modulus(input mm384_pkg::mod_t m, input mm384_pkg::limb_t ninv);
    for (int i = 0; i < ML; i++) write_reg(i[CIW-1:0], m[i]);
    write_reg(mm384_pkg::CFG_NEG_INV, ninv);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_mod = m;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // random operand, sometimes just under the modulus
  function automatic mm384_pkg::mod_t rand_operand();
    mm384_pkg::mod_t v;
    for (int i = 0; i < ML; i++) v[i] = rand_limb();
    if ($urandom_range(4) == 0) begin
      v = cur_mod;
      v[0] = v[0] - 64'($urandom_range(1, 3));
    end else if ($urandom_range(4) == 0) begin
      v[ML-1] = v[ML-1] >> $urandom_range(63);
    end
    return v;
  endfunction

  initial begin
    mm384_pkg::mod_t pm1, ones, one, alt_a, alt_b, m;
    pm1 = mm384_pkg::MOD_RESET;
    pm1[0] = pm1[0] - 1;
    ones = '1;
    one = '0;
    one[0] = 64'd1;
    alt_a = {ML{64'haaaaaaaaaaaaaaaa}};
    alt_b = {ML{64'h5555555555555555}};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under the reset modulus
    send_word('0, '0);
    send_word(one, one);
    send_word(pm1, pm1);
    send_word(pm1, one);
    send_word(mm384_pkg::MOD_RESET, one);
    send_word(ones, ones);
    send_word(ones, '0);
    send_word(alt_a, alt_b);
    send_word(alt_b, alt_a);
    send_word(ones, one);
    send_word(one, pm1);
    for (int k = 0; k < 6; k++) begin
      m = '0;
      m[k] = 64'h8000000000000001;
      send_word(m, pm1);
    end
    send_word(rand_operand(), ones);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: load_modulus(ones, 64'd1);
        2: begin
          for (int i = 0; i < ML; i++) m[i] = rand_limb();
          m[0][0] = 1'b1;
          load_modulus(m, neg_inverse(m[0]));
        end
        3: load_modulus(one, '1);
        4: begin
          // even modulus with an unrelated inverse word
          for (int i = 0; i < ML; i++) m[i] = rand_limb();
          m[0][0] = 1'b0;
          load_modulus(m, rand_limb());
        end
        5: load_modulus(mm384_pkg::MOD_RESET, mm384_pkg::NEG_INV_RESET);
        default: ;
      endcase
      if (ph < 2) begin
        send_idle_pct = 8;
        recv_stall_pct = 71;
      end else if (ph < 4) begin
        send_idle_pct = 71;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (ph == 4) load_modulus('0, '0);
      repeat (90) send_word(rand_operand(), rand_operand());
      drain();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
